FILE: sv/gcns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gcns_pkg;
    localparam int MAX_PARTICLES = 1024;
    localparam int MAX_CELLS = 1024;
    localparam int CELL_CAPACITY = 8;
    localparam int MAX_NEIGHBORS = 32;
    localparam int HIT_LIMIT = 32;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_INV_W = 3'd2;
    localparam logic [2:0] REG_INV_H = 3'd3;
    localparam logic [2:0] REG_COLS = 3'd4;
    localparam logic [2:0] REG_ROWS = 3'd5;
    localparam logic [2:0] REG_RADIUS = 3'd6;
endpackage
`default_nettype wire

FILE: sv/grid_cell_neighbor_search.sv
`timescale 1ns / 1ps
`default_nettype none
// Clear clears one cell count per cycle. A load bins the particle into its cell; a query scans
// the 3x3 block of cells around the queried particle's cell, skipping cells off the grid and
// the queried particle itself, then emits the neighbour beats.
// One item at a time; in_stall stays high until every result beat is taken.
// Reset (rst_n, asynchronous, active low) empties the particle store, restores the register
// defaults, then holds in_stall while the cell counts are cleared.
module grid_cell_neighbor_search #(
    parameter int MAX_PARTICLES = gcns_pkg::MAX_PARTICLES,
    parameter int MAX_CELLS = gcns_pkg::MAX_CELLS,
    parameter int CELL_CAPACITY = gcns_pkg::CELL_CAPACITY,
    parameter int MAX_NEIGHBORS = gcns_pkg::MAX_NEIGHBORS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [15:0] pos_x,
    input  wire logic [15:0] pos_y,
    input  wire logic [9:0]  query_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [9:0]       self_index,
    output logic [9:0]       neighbor_index,
    output logic signed [16:0] delta_x,
    output logic signed [16:0] delta_y,
    output logic [32:0]      dist_sq,
    output logic             valid_res,
    output logic             overflow,
    output logic             last
);
    localparam int PW = (MAX_PARTICLES > 2) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int KW = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
    localparam int FW = $clog2(CELL_CAPACITY + 1);
    localparam int TW = $clog2(MAX_PARTICLES + 1);
    localparam int HCAP = (MAX_NEIGHBORS < gcns_pkg::HIT_LIMIT) ?
                          MAX_NEIGHBORS : gcns_pkg::HIT_LIMIT;
    localparam int HW = $clog2(HCAP + 1);
    localparam int HIW = (HCAP > 1) ? $clog2(HCAP) : 1;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_CLR, S_LOC0, S_LOC1, S_LOC2, S_LOAD_CELL, S_LOAD_WAIT,
        S_LOAD_FILL, S_QREAD, S_QPOS, S_CELL, S_FWAIT, S_CFILL, S_MREAD, S_MWAIT,
        S_PREAD, S_PWAIT, S_DX, S_DY, S_ACC, S_EMIT, S_HREAD, S_HWAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic [15:0] ox_reg, oy_reg, iw_reg, ih_reg;
    logic [5:0]  cols_reg, rows_reg;
    logic [32:0] rad_reg;
    logic [TW-1:0] total_reg;

    logic [15:0] store_x [MAX_PARTICLES];
    logic [15:0] store_y [MAX_PARTICLES];
    logic [FW-1:0] cell_fill [MAX_CELLS];
    logic [PW-1:0] cell_members [MAX_CELLS*CELL_CAPACITY];
    logic [PW-1:0] hit_nb [HCAP];
    logic [16:0] hit_dx [HCAP];
    logic [16:0] hit_dy [HCAP];
    logic [32:0] hit_d2 [HCAP];

    logic [1:0]  act_reg;
    logic [15:0] px_reg, py_reg;
    logic [9:0]  qi_reg;
    logic [PW-1:0] idx_reg;
    logic [CW-1:0] cidx_reg;
    logic [31:0] prod_reg;
    logic [16:0] ux_reg, uy_reg;
    logic [31:0] col_reg, row_reg;
    logic [1:0]  dr_reg, dc_reg;
    logic [FW-1:0] fill_reg, m_reg;
    logic [PW-1:0] j_reg;
    logic [15:0] rx_reg, ry_reg;
    logic [FW-1:0] rfill_reg;
    logic [PW-1:0] rmem_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic [32:0] sq_reg;
    logic [HW-1:0] cnt_reg, k_reg;
    logic ovf_reg;

    logic signed [7:0] rr, cc;
    logic [11:0] cell_calc;
    logic [33:0] sq_mul;
    logic [33:0] d2_sum;

    assign pready = 1'b1;
    assign in_stall = (state_reg != S_IDLE);
    always_comb
    begin
        unique case (paddr[5:3])
            gcns_pkg::REG_ORIGIN_X: prdata = {48'd0, ox_reg};
            gcns_pkg::REG_ORIGIN_Y: prdata = {48'd0, oy_reg};
            gcns_pkg::REG_INV_W:    prdata = {48'd0, iw_reg};
            gcns_pkg::REG_INV_H:    prdata = {48'd0, ih_reg};
            gcns_pkg::REG_COLS:     prdata = {58'd0, cols_reg};
            gcns_pkg::REG_ROWS:     prdata = {58'd0, rows_reg};
            gcns_pkg::REG_RADIUS:   prdata = {31'd0, rad_reg};
            default:                prdata = 64'd0;
        endcase
    end

    assign rr = $signed({2'b00, row_reg[5:0]}) + $signed({6'd0, dr_reg}) - 8'sd1;
    assign cc = $signed({2'b00, col_reg[5:0]}) + $signed({6'd0, dc_reg}) - 8'sd1;
    assign cell_calc = 12'(rr[5:0]) * 12'(cols_reg) + 12'(cc[5:0]);
    assign sq_mul = 34'($signed(dx_reg) * $signed(dx_reg));
    assign d2_sum = {1'b0, sq_reg} + 34'($signed(dy_reg) * $signed(dy_reg));

    // memories
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && action == gcns_pkg::ACT_LOAD &&
            total_reg < TW'(MAX_PARTICLES))
        begin
            store_x[total_reg[PW-1:0]] <= pos_x;
            store_y[total_reg[PW-1:0]] <= pos_y;
        end
        rx_reg <= store_x[j_reg];
        ry_reg <= store_y[j_reg];
        rmem_reg <= cell_members[{cidx_reg, m_reg[KW-1:0]}];
        if (state_reg == S_LOAD_FILL && rfill_reg < FW'(CELL_CAPACITY))
            cell_members[{cidx_reg, rfill_reg[KW-1:0]}] <= idx_reg;
        if (state_reg == S_ACC && d2_sum[32:0] <= rad_reg && cnt_reg < HW'(HCAP))
        begin
            hit_nb[cnt_reg[HIW-1:0]] <= j_reg;
            hit_dx[cnt_reg[HIW-1:0]] <= dx_reg;
            hit_dy[cnt_reg[HIW-1:0]] <= dy_reg;
            hit_d2[cnt_reg[HIW-1:0]] <= d2_sum[32:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rfill_reg <= '0;
        end
        else
        begin
            rfill_reg <= cell_fill[cidx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLR || state_reg == S_INIT)
            cell_fill[cidx_reg] <= '0;
        else if (state_reg == S_LOAD_FILL && rfill_reg < FW'(CELL_CAPACITY))
            cell_fill[cidx_reg] <= rfill_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            ox_reg <= '0; oy_reg <= '0;
            iw_reg <= 16'd256; ih_reg <= 16'd256;
            cols_reg <= 6'd32; rows_reg <= 6'd32;
            rad_reg <= 33'd65536;
            total_reg <= '0;
            out_valid <= 1'b0;
            act_reg <= '0; px_reg <= '0; py_reg <= '0; qi_reg <= '0;
            idx_reg <= '0; cidx_reg <= '0; prod_reg <= '0;
            ux_reg <= '0; uy_reg <= '0; col_reg <= '0; row_reg <= '0;
            dr_reg <= '0; dc_reg <= '0; fill_reg <= '0; m_reg <= '0;
            j_reg <= '0;
            dx_reg <= '0; dy_reg <= '0; sq_reg <= '0;
            cnt_reg <= '0; k_reg <= '0; ovf_reg <= 1'b0;
            self_index <= '0; neighbor_index <= '0; delta_x <= '0; delta_y <= '0;
            dist_sq <= '0; valid_res <= 1'b0; overflow <= 1'b0; last <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                unique case (paddr[5:3])
                    gcns_pkg::REG_ORIGIN_X: ox_reg <= pwdata[15:0];
                    gcns_pkg::REG_ORIGIN_Y: oy_reg <= pwdata[15:0];
                    gcns_pkg::REG_INV_W:    iw_reg <= pwdata[15:0];
                    gcns_pkg::REG_INV_H:    ih_reg <= pwdata[15:0];
                    gcns_pkg::REG_COLS:     cols_reg <= pwdata[5:0];
                    gcns_pkg::REG_ROWS:     rows_reg <= pwdata[5:0];
                    gcns_pkg::REG_RADIUS:   rad_reg <= pwdata[32:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_INIT:
                begin
                    if (32'(cidx_reg) == MAX_CELLS - 1)
                        state_reg <= S_IDLE;
                    cidx_reg <= cidx_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg <= action;
                        qi_reg <= query_index;
                        px_reg <= pos_x;
                        py_reg <= pos_y;
                        self_index <= '0; neighbor_index <= '0;
                        delta_x <= '0; delta_y <= '0; dist_sq <= '0;
                        valid_res <= 1'b0; overflow <= 1'b0; last <= 1'b1;
                        cnt_reg <= '0; ovf_reg <= 1'b0; k_reg <= '0;
                        unique case (action)
                            gcns_pkg::ACT_CLEAR:
                            begin
                                total_reg <= '0;
                                cidx_reg <= '0;
                                state_reg <= S_CLR;
                            end
                            gcns_pkg::ACT_LOAD:
                            begin
                                if (total_reg >= TW'(MAX_PARTICLES))
                                begin
                                    overflow <= 1'b1;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    idx_reg <= total_reg[PW-1:0];
                                    self_index <= 10'(total_reg[PW-1:0]);
                                    total_reg <= total_reg + 1'b1;
                                    state_reg <= S_LOC0;
                                end
                            end
                            gcns_pkg::ACT_QUERY:
                            begin
                                self_index <= query_index;
                                if (TW'(query_index) >= total_reg)
                                    state_reg <= S_OUT;
                                else
                                begin
                                    j_reg <= PW'(query_index);
                                    state_reg <= S_QREAD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLR:
                begin
                    if (32'(cidx_reg) == MAX_CELLS - 1)
                        state_reg <= S_OUT;
                    cidx_reg <= cidx_reg + 1'b1;
                end
                S_QREAD: state_reg <= S_QPOS;
                S_QPOS:
                begin
                    px_reg <= rx_reg;
                    py_reg <= ry_reg;
                    state_reg <= S_LOC0;
                end
                S_LOC0:
                begin
                    ux_reg <= {1'b0, px_reg} - {1'b0, ox_reg};
                    uy_reg <= {1'b0, py_reg} - {1'b0, oy_reg};
                    state_reg <= S_LOC1;
                end
                S_LOC1:
                begin
                    col_reg <= 32'(ux_reg[15:0] * iw_reg) >> 16;
                    state_reg <= S_LOC2;
                end
                S_LOC2:
                begin
                    prod_reg <= 32'(uy_reg[15:0] * ih_reg) >> 16;
                    row_reg <= 32'(uy_reg[15:0] * ih_reg) >> 16;
                    dr_reg <= '0; dc_reg <= '0;
                    if (ux_reg[16] || uy_reg[16] || col_reg >= 32'(cols_reg) ||
                        (32'(uy_reg[15:0] * ih_reg) >> 16) >= 32'(rows_reg))
                        state_reg <= S_OUT;
                    else if (act_reg == gcns_pkg::ACT_LOAD)
                        state_reg <= S_LOAD_CELL;
                    else
                        state_reg <= S_CELL;
                end
                S_LOAD_CELL:
                begin
                    if (prod_reg * 32'(cols_reg) + col_reg >= 32'(MAX_CELLS))
                        state_reg <= S_OUT;
                    else
                    begin
                        cidx_reg <= CW'(prod_reg * 32'(cols_reg) + col_reg);
                        state_reg <= S_LOAD_WAIT;
                    end
                end
                S_LOAD_WAIT: state_reg <= S_LOAD_FILL;
                S_LOAD_FILL:
                begin
                    if (rfill_reg < FW'(CELL_CAPACITY))
                        valid_res <= 1'b1;
                    else
                        overflow <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_CELL:
                begin
                    if (rr < 0 || cc < 0 || rr >= $signed({2'b00, rows_reg}) ||
                        cc >= $signed({2'b00, cols_reg}) ||
                        32'(cell_calc) >= MAX_CELLS)
                        state_reg <= S_CFILL;
                    else
                    begin
                        cidx_reg <= CW'(cell_calc);
                        state_reg <= S_FWAIT;
                    end
                    m_reg <= '0;
                    fill_reg <= '0;
                end
                S_FWAIT: state_reg <= S_MREAD;
                S_MREAD:
                begin
                    fill_reg <= (rfill_reg > FW'(CELL_CAPACITY)) ?
                                FW'(CELL_CAPACITY) : rfill_reg;
                    state_reg <= S_MWAIT;
                end
                S_MWAIT:
                begin
                    if (m_reg >= fill_reg)
                        state_reg <= S_CFILL;
                    else
                        state_reg <= S_PREAD;
                end
                S_PREAD:
                begin
                    j_reg <= rmem_reg;
                    if (10'(rmem_reg) == qi_reg)
                    begin
                        m_reg <= m_reg + 1'b1;
                        state_reg <= S_MWAIT;
                    end
                    else
                        state_reg <= S_PWAIT;
                end
                S_PWAIT: state_reg <= S_DX;
                S_DX:
                begin
                    dx_reg <= $signed({1'b0, px_reg}) - $signed({1'b0, rx_reg});
                    dy_reg <= $signed({1'b0, py_reg}) - $signed({1'b0, ry_reg});
                    state_reg <= S_DY;
                end
                S_DY:
                begin
                    sq_reg <= sq_mul[32:0];
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (d2_sum[32:0] <= rad_reg)
                    begin
                        if (cnt_reg < HW'(HCAP))
                            cnt_reg <= cnt_reg + 1'b1;
                        else
                            ovf_reg <= 1'b1;
                    end
                    m_reg <= m_reg + 1'b1;
                    state_reg <= S_EMIT;
                end
                S_EMIT: state_reg <= S_MWAIT;
                S_CFILL:
                begin
                    if (dc_reg != 2'd2)
                    begin
                        dc_reg <= dc_reg + 1'b1;
                        state_reg <= S_CELL;
                    end
                    else if (dr_reg != 2'd2)
                    begin
                        dc_reg <= '0;
                        dr_reg <= dr_reg + 1'b1;
                        state_reg <= S_CELL;
                    end
                    else if (cnt_reg == '0)
                    begin
                        overflow <= ovf_reg;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_HREAD;
                end
                S_HREAD:
                begin
                    neighbor_index <= 10'(hit_nb[k_reg[HIW-1:0]]);
                    delta_x <= hit_dx[k_reg[HIW-1:0]];
                    delta_y <= hit_dy[k_reg[HIW-1:0]];
                    dist_sq <= hit_d2[k_reg[HIW-1:0]];
                    valid_res <= 1'b1;
                    overflow <= ovf_reg;
                    last <= (k_reg + 1'b1 == cnt_reg);
                    k_reg <= k_reg + 1'b1;
                    out_valid <= 1'b1;
                    state_reg <= S_HWAIT;
                end
                S_HWAIT:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= last ? S_IDLE : S_HREAD;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid)
                        out_valid <= 1'b1;
                    else if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: sv/gcns_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module gcns_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic [1:0] action,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic last,
    input wire logic valid_res,
    input wire logic [32:0] dist_sq
);
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action != gcns_pkg::ACT_IGNORED |=> in_stall)
        else $error("not busy after beat");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dist_sq))
        else $error("result dropped");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> dist_sq == 33'd0) else $error("stray distance");
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last |=> !out_valid) else $error("extra beat");
endmodule
bind grid_cell_neighbor_search gcns_checker u_gcns_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .out_valid(out_valid), .out_stall(out_stall), .last(last),
    .valid_res(valid_res), .dist_sq(dist_sq)
);
`default_nettype wire
